// File: rtl/rbs_pkg.sv
// Shared widths, limits and the broadcast bundle of the room booking scheduler.
package rbs_pkg;

  localparam int MAX_ROOMS_DEF = 16;
  localparam int TIME_W        = 32;
  localparam int FREE_W        = 48;
  localparam int CNT_W         = 32;
  localparam int ROOM_W        = 4;
  localparam int RC_W          = 5;
  localparam int RC_RESET      = 16;

  localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [FREE_W-1:0] wr_free;
    logic              clear;
  } rbs_bc_t;

endpackage

// File: rtl/rbs_cell.sv
// One room cell: holds free time and booking count, folds them into the passing search record.
module rbs_cell
  import rbs_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int IDX_W  = 4,
  parameter int NCNT_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [NCNT_W-1:0] n_act,
  input  rbs_bc_t           bc,
  input  logic              wr_en,
  input  logic              in_vld,
  input  logic              in_found,
  input  logic [IDX_W-1:0]  in_first,
  input  logic [FREE_W-1:0] in_min,
  input  logic [IDX_W-1:0]  in_min_idx,
  input  logic [CNT_W-1:0]  in_best_cnt,
  input  logic [IDX_W-1:0]  in_best,
  output logic              out_vld,
  output logic              out_found,
  output logic [IDX_W-1:0]  out_first,
  output logic [FREE_W-1:0] out_min,
  output logic [IDX_W-1:0]  out_min_idx,
  output logic [CNT_W-1:0]  out_best_cnt,
  output logic [IDX_W-1:0]  out_best
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [FREE_W-1:0] free_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              vld_r;
  logic              found_r;
  logic [IDX_W-1:0]  first_r;
  logic [FREE_W-1:0] min_r;
  logic [IDX_W-1:0]  min_idx_r;
  logic [CNT_W-1:0]  best_cnt_r;
  logic [IDX_W-1:0]  best_r;

  logic              active;
  logic              take_first;
  logic              take_min;
  logic              take_best;

  assign active     = n_act > NCNT_W'(IDX);
  assign take_first = active && !in_found && (free_r <= {{(FREE_W-TIME_W){1'b0}}, bc.start});
  assign take_min   = active && (free_r < in_min);
  assign take_best  = active && (cnt_r > in_best_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n || bc.clear) begin
      free_r <= '0;
      cnt_r  <= '0;
    end else if (wr_en) begin
      free_r <= bc.wr_free;
      if (cnt_r != CNT_MAX) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    found_r    <= in_found || take_first;
    first_r    <= take_first ? MY_IDX : in_first;
    min_r      <= take_min ? free_r : in_min;
    min_idx_r  <= take_min ? MY_IDX : in_min_idx;
    best_cnt_r <= take_best ? cnt_r : in_best_cnt;
    best_r     <= take_best ? MY_IDX : in_best;
  end

  assign out_vld      = vld_r;
  assign out_found    = found_r;
  assign out_first    = first_r;
  assign out_min      = min_r;
  assign out_min_idx  = min_idx_r;
  assign out_best_cnt = best_cnt_r;
  assign out_best     = best_r;

endmodule

// File: rtl/room_booking_scheduler.sv
// Room booking scheduler top level: control sequencer, configuration port and the cell chain.
// Each transaction makes two record sweeps over the cell chain, one to choose the room and one
// for the most-booked room; no new transaction is taken until its result is registered.
// A result waits in the output register while the next transaction is taken.
// Reset (synchronous, active low) zeroes every room and sets room_count to 16.
module room_booking_scheduler
  import rbs_pkg::*;
#(
  parameter int MAX_ROOMS = MAX_ROOMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] in_start_time,
  input  logic [TIME_W-1:0] in_end_time,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ROOM_W-1:0] out_room,
  output logic              out_delayed,
  output logic [ROOM_W-1:0] out_most_booked,
  output logic              out_last_res
);

  localparam int IDX_W  = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int NCNT_W = $clog2(MAX_ROOMS + 1);
  localparam int CMP_W  = (RC_W > NCNT_W) ? RC_W : NCNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_UPD,
    S_SCAN_B,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [RC_W-1:0]     room_count_r;
  logic                launch_r;
  logic                clear_r;
  logic [TIME_W-1:0]   start_r;
  logic [TIME_W-1:0]   dur_r;
  logic                last_r;
  logic [IDX_W-1:0]    room_r;
  logic                delayed_r;
  logic [IDX_W-1:0]    best_r;
  logic [FREE_W-1:0]   wr_free_r;
  logic                out_vld_r;
  logic [ROOM_W-1:0]   out_room_r;
  logic                out_delayed_r;
  logic [ROOM_W-1:0]   out_best_r;
  logic                out_last_r;

  logic [CMP_W-1:0]    rc_ext;
  logic [NCNT_W-1:0]   n_act;
  rbs_bc_t             bc;
  logic [MAX_ROOMS-1:0] wr_sel;
  logic                in_acc;
  logic                cfg_wr;
  logic [FREE_W-1:0]   base;
  logic [FREE_W:0]     sum;

  logic                c_vld      [MAX_ROOMS+1];
  logic                c_found    [MAX_ROOMS+1];
  logic [IDX_W-1:0]    c_first    [MAX_ROOMS+1];
  logic [FREE_W-1:0]   c_min      [MAX_ROOMS+1];
  logic [IDX_W-1:0]    c_min_idx  [MAX_ROOMS+1];
  logic [CNT_W-1:0]    c_best_cnt [MAX_ROOMS+1];
  logic [IDX_W-1:0]    c_best     [MAX_ROOMS+1];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-RC_W){1'b0}}, room_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_count_r <= RC_W'(RC_RESET);
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      room_count_r <= pwdata[RC_W-1:0];
    end
  end

  always_comb begin
    rc_ext = CMP_W'(room_count_r);
    if (rc_ext == '0) begin
      n_act = NCNT_W'(1);
    end else if (rc_ext > CMP_W'(MAX_ROOMS)) begin
      n_act = NCNT_W'(MAX_ROOMS);
    end else begin
      n_act = NCNT_W'(rc_ext);
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign bc.start   = start_r;
  assign bc.wr_free = wr_free_r;
  assign bc.clear   = clear_r;

  assign c_vld[0]      = launch_r;
  assign c_found[0]    = 1'b0;
  assign c_first[0]    = '0;
  assign c_min[0]      = FREE_MAX;
  assign c_min_idx[0]  = '0;
  assign c_best_cnt[0] = '0;
  assign c_best[0]     = '0;

  for (genvar i = 0; i < MAX_ROOMS; i++) begin : g_cell
    assign wr_sel[i] = (state_r == S_UPD) && (room_r == IDX_W'(i));

    rbs_cell #(
      .IDX    (i),
      .IDX_W  (IDX_W),
      .NCNT_W (NCNT_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .n_act        (n_act),
      .bc           (bc),
      .wr_en        (wr_sel[i]),
      .in_vld       (c_vld[i]),
      .in_found     (c_found[i]),
      .in_first     (c_first[i]),
      .in_min       (c_min[i]),
      .in_min_idx   (c_min_idx[i]),
      .in_best_cnt  (c_best_cnt[i]),
      .in_best      (c_best[i]),
      .out_vld      (c_vld[i+1]),
      .out_found    (c_found[i+1]),
      .out_first    (c_first[i+1]),
      .out_min      (c_min[i+1]),
      .out_min_idx  (c_min_idx[i+1]),
      .out_best_cnt (c_best_cnt[i+1]),
      .out_best     (c_best[i+1])
    );
  end

  assign base = c_found[MAX_ROOMS] ? {{(FREE_W-TIME_W){1'b0}}, start_r} : c_min[MAX_ROOMS];
  assign sum  = {1'b0, base} + {{(FREE_W+1-TIME_W){1'b0}}, dur_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      launch_r  <= 1'b0;
      clear_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      launch_r  <= in_acc || (state_r == S_UPD);
      clear_r   <= (state_r == S_DONE) && (!out_vld_r || !out_stall) && last_r;
      out_vld_r <= (state_r == S_DONE) || (out_vld_r && out_stall);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            start_r  <= in_start_time;
            dur_r    <= (in_end_time > in_start_time) ? in_end_time - in_start_time : '0;
            last_r   <= in_last;
            state_r  <= S_SCAN_A;
          end
        end
        S_SCAN_A: begin
          if (c_vld[MAX_ROOMS]) begin
            room_r    <= c_found[MAX_ROOMS] ? c_first[MAX_ROOMS] : c_min_idx[MAX_ROOMS];
            delayed_r <= !c_found[MAX_ROOMS];
            wr_free_r <= sum[FREE_W] ? FREE_MAX : sum[FREE_W-1:0];
            state_r   <= S_UPD;
          end
        end
        S_UPD: begin
          state_r  <= S_SCAN_B;
        end
        S_SCAN_B: begin
          if (c_vld[MAX_ROOMS]) begin
            best_r  <= c_best[MAX_ROOMS];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_r || !out_stall) begin
            out_room_r    <= ROOM_W'(room_r);
            out_delayed_r <= delayed_r;
            out_best_r    <= ROOM_W'(best_r);
            out_last_r    <= last_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_vld_r;
  assign out_room        = out_room_r;
  assign out_delayed     = out_delayed_r;
  assign out_most_booked = out_best_r;
  assign out_last_res    = out_last_r;

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    c_vld[MAX_ROOMS] |-> (state_r == S_SCAN_A || state_r == S_SCAN_B))
    else $error("search record left the chain outside a scan");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_sel))
    else $error("more than one room written");

  a_launch_scan: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> (state_r == S_SCAN_A || state_r == S_SCAN_B))
    else $error("record launched outside a scan");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> $past(state_r == S_DONE) && out_vld_r && out_last_r)
    else $error("rooms cleared without a final result");

endmodule

// File: tb/sv/room_booking_scheduler_test.sv
// Self-checking testbench for the room booking scheduler: stimulus, prediction and checking.
`timescale 1ns / 100ps

module room_booking_scheduler_test
  import rbs_pkg::*;
;

  localparam logic [2:0] ROOM_COUNT_ADDR = 3'd0;
  localparam int SETTLE_CYCLES = 2 * MAX_ROOMS_DEF + 8;
  localparam int PRESSURE_CYCLES = 400;

  typedef struct packed {
    logic [ROOM_W-1:0] room;
    logic              delayed;
    logic [ROOM_W-1:0] most_booked;
    logic              last_res;
  } room_result_t;

  class booking_board;
    logic [RC_W-1:0]   room_count;
    logic [FREE_W-1:0] free_at [MAX_ROOMS_DEF];
    logic [CNT_W-1:0]  bookings [MAX_ROOMS_DEF];
    room_result_t      expected_rooms [$];
    int                errors;

    function new();
      room_count = RC_W'(RC_RESET);
      errors = 0;
      clear_rooms();
    endfunction

    function void clear_rooms();
      foreach (free_at[i]) begin
        free_at[i] = '0;
        bookings[i] = '0;
      end
    endfunction

    function int active_rooms();
      if (room_count == 0) return 1;
      if (room_count > MAX_ROOMS_DEF) return MAX_ROOMS_DEF;
      return int'(room_count);
    endfunction

    function void note_booking(logic [TIME_W-1:0] start_t, logic [TIME_W-1:0] end_t,
                               logic last_f);
      logic [TIME_W-1:0] dur;
      logic [FREE_W:0]   free_next;
      int                n;
      int                pick;
      int                best;
      bit                found;
      room_result_t      r;
      dur = (end_t > start_t) ? end_t - start_t : '0;
      n = active_rooms();
      found = 0;
      pick = 0;
      for (int i = 0; i < n && !found; i++) begin
        if (free_at[i] <= FREE_W'(start_t)) begin
          pick = i;
          found = 1;
        end
      end
      if (found) begin
        free_next = (FREE_W+1)'(start_t) + dur;
      end else begin
        for (int i = 1; i < n; i++)
          if (free_at[i] < free_at[pick]) pick = i;
        free_next = {1'b0, free_at[pick]} + dur;
      end
      free_at[pick] = (free_next > FREE_MAX) ? FREE_MAX : free_next[FREE_W-1:0];
      if (bookings[pick] != CNT_MAX) bookings[pick] = bookings[pick] + 1'b1;
      best = 0;
      for (int i = 1; i < n; i++)
        if (bookings[i] > bookings[best]) best = i;
      r.room = ROOM_W'(pick);
      r.delayed = !found;
      r.most_booked = ROOM_W'(best);
      r.last_res = last_f;
      expected_rooms.push_back(r);
      if (last_f) clear_rooms();
    endfunction

    task report_mismatch(string field, int got_v, int exp_v);
      errors++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got_v, exp_v);
    endtask

    task check_result(room_result_t got);
      room_result_t exp;
      if (expected_rooms.size() == 0) begin
        report_mismatch("result with no booking pending", got.room, -1);
      end else begin
        exp = expected_rooms.pop_front();
        if (got.room !== exp.room) report_mismatch("room", got.room, exp.room);
        if (got.delayed !== exp.delayed) report_mismatch("delayed", got.delayed, exp.delayed);
        if (got.most_booked !== exp.most_booked)
          report_mismatch("most_booked", got.most_booked, exp.most_booked);
        if (got.last_res !== exp.last_res)
          report_mismatch("last_res", got.last_res, exp.last_res);
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TIME_W-1:0] in_start_time = '0;
  logic [TIME_W-1:0] in_end_time = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ROOM_W-1:0] out_room;
  logic              out_delayed;
  logic [ROOM_W-1:0] out_most_booked;
  logic              out_last_res;

  booking_board sb = new();

  int burst_left = 1;
  int pressure_cnt = 0;
  int pressure_seen = 0;
  int hold_left = 0;
  int recv_tick = 0;
  int recv_mode = 0;
  logic [7:0] stall_ring = 8'h5a;

  room_booking_scheduler #(.MAX_ROOMS(MAX_ROOMS_DEF)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_time   (in_start_time),
    .in_end_time     (in_end_time),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_room        (out_room),
    .out_delayed     (out_delayed),
    .out_most_booked (out_most_booked),
    .out_last_res    (out_last_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(room_result_t'{out_room, out_delayed, out_most_booked, out_last_res});
    if (pressure_cnt != pressure_seen) begin
      pressure_seen = pressure_cnt;
      hold_left = PRESSURE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (recv_tick % 48 == 0) begin
        recv_mode = $urandom_range(0, 3);
        stall_ring = $urandom;
      end
      recv_tick++;
      case (recv_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 1);
        2: out_stall <= ($urandom_range(0, 7) == 0);
        default: begin
          out_stall <= stall_ring[0];
          stall_ring = {stall_ring[0], stall_ring[7:1]};
        end
      endcase
    end
  end

  task automatic offer(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                       input logic l);
    int gap;
    in_valid <= 1'b1;
    in_start_time <= s;
    in_end_time <= e;
    in_last <= l;
    do @(posedge clk); while (in_stall);
    sb.note_booking(s, e, l);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sb.expected_rooms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_room_count(input logic [RC_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ROOM_COUNT_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.room_count = value;
  endtask

  task automatic run_bookings(input int quota);
    int sent;
    int kind;
    int len;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    logic [TIME_W-1:0] step_max;
    logic l;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        offer($urandom, $urandom, $urandom_range(0, 3) == 0);
        sent++;
      end else begin
        len = $urandom_range(1, 24);
        s = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
        step_max = ($urandom_range(0, 1) == 1) ? 4 : 60;
        for (int k = 0; k < len; k++) begin
          if (kind == 1) s = $urandom_range(0, 2000);
          else s = s + $urandom_range(0, step_max);
          case ($urandom_range(0, 9))
            0: e = s;
            1: e = s - $urandom_range(1, 100);
            2: e = $urandom;
            default: e = s + $urandom_range(1, 80);
          endcase
          if (k != len - 1) l = 1'b0;
          else l = (kind == 1) ? $urandom_range(0, 1) : 1'b1;
          offer(s, e, l);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int phase_counts [8];
    phase_counts = '{0, 1, 31, 3, 16, 17, 2, 0};
    phase_counts[7] = $urandom_range(1, 16);
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset room count, extreme times
    offer(32'h0, 32'hffff_ffff, 1'b0);
    offer(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    settle_idle();

    // two rooms: empty, reversed, postponed and out-of-order bookings
    write_room_count(5'd2);
    offer(32'd0, 32'd0, 1'b0);
    offer(32'd0, 32'd10, 1'b0);
    offer(32'd0, 32'd5, 1'b0);
    offer(32'd3, 32'd4, 1'b0);
    offer(32'd4, 32'd2, 1'b0);
    offer(32'd6, 32'd9, 1'b0);
    offer(32'd7, 32'd7, 1'b0);
    offer(32'd2, 32'd50, 1'b0);
    offer(32'd0, 32'hffff_ffff, 1'b0);
    offer(32'hffff_ffff, 32'd0, 1'b0);
    offer(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    offer(32'd0, 32'd10, 1'b0);
    offer(32'd0, 32'd10, 1'b0);
    offer(32'd1, 32'd2, 1'b1);
    settle_idle();

    foreach (phase_counts[p]) begin
      write_room_count(RC_W'(phase_counts[p]));
      if (p == 3) pressure_cnt++;
      run_bookings(115);
      settle_idle();
    end

    if (sb.expected_rooms.size() != 0)
      sb.report_mismatch("bookings without result", sb.expected_rooms.size(), 0);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
